// File: rtl/rttpto_pkg.sv
// ----------------------------------------------------------------------------
// rttpto_pkg: shared types and constants
// Widths, status codes and the estimator state record for the RTT/PTO block.
// ----------------------------------------------------------------------------
`default_nettype none

package rttpto_pkg;

  localparam int TIME_W  = 32;
  localparam int PTO_W   = 35;
  localparam int DELAY_W = 24;

  localparam logic [PTO_W-1:0] PTO_NONE  = 35'd200000;
  localparam logic [PTO_W-1:0] PTO_FLOOR = 35'd1000;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_ZERO = 1'b1
  } status_t;

  typedef struct packed {
    logic [TIME_W-1:0] latest;
    logic [TIME_W-1:0] minimum;
    logic [TIME_W-1:0] smoothed;
    logic [TIME_W-1:0] deviation;
  } rtt_state_t;

endpackage

`default_nettype wire

// File: rtl/rttpto_ifs.sv
// ----------------------------------------------------------------------------
// rttpto_ifs: channel interfaces
// Valid/ready channels for RTT samples in and estimator results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rttpto_in_if;
  logic                            valid;
  logic                            ready;
  logic [rttpto_pkg::TIME_W-1:0]   rtt_sample;
  logic [rttpto_pkg::TIME_W-1:0]   ack_delay;

  modport source (output valid, output rtt_sample, output ack_delay, input ready);
  modport sink   (input valid, input rtt_sample, input ack_delay, output ready);
endinterface

interface rttpto_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [rttpto_pkg::TIME_W-1:0] latest_rtt;
  logic [rttpto_pkg::TIME_W-1:0] min_rtt;
  logic [rttpto_pkg::TIME_W-1:0] smoothed_rtt;
  logic [rttpto_pkg::TIME_W-1:0] rtt_deviation;
  logic [rttpto_pkg::PTO_W-1:0]  pto_base;
  logic [rttpto_pkg::PTO_W-1:0]  pto_with_delay;

  modport source (output valid, output status, output latest_rtt, output min_rtt,
                  output smoothed_rtt, output rtt_deviation, output pto_base,
                  output pto_with_delay, input ready);
  modport sink   (input valid, input status, input latest_rtt, input min_rtt,
                  input smoothed_rtt, input rtt_deviation, input pto_base,
                  input pto_with_delay, output ready);
endinterface

`default_nettype wire

// File: rtl/rtt_estimator_pto.sv
// ----------------------------------------------------------------------------
// rtt_estimator_pto: RTT estimator with probe timeout
// Tracks min, latest, smoothed RTT and deviation; reports PTO per sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction per RTT sample (rtt_sample, ack_delay, in us).
//   out_ch : one transaction per input: status, the four estimator values
//            after the update, and the PTO with and without max ack delay.
//   cfg_we/cfg_wdata : write max_ack_delay; write only while idle.
// Pipeline: input register -> state update (estimator registers and a
//   snapshot) -> PTO adders -> output register. Throughput is one
//   transaction per cycle while out_ch.ready stays high.
// A zero sample returns status 1 and leaves the estimator untouched.
// Reset clears all stages and the estimator (no sample yet, PTO 200000)
//   and sets max_ack_delay to 0.
// Receiver stall: each stage holds while the next one is full and blocked;
//   empty stages still take new transactions, so up to three stay in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_estimator_pto (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  rttpto_in_if.sink                               in_ch,
  rttpto_out_if.source                            out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [rttpto_pkg::DELAY_W-1:0]     cfg_wdata
);

  // configuration
  logic [rttpto_pkg::DELAY_W-1:0] max_ack_delay_r;

  // stage 1: captured sample
  logic                          s1_valid_r;
  logic [rttpto_pkg::TIME_W-1:0] s1_sample_r;
  logic [rttpto_pkg::TIME_W-1:0] s1_ack_r;

  // estimator state and stage 2 snapshot
  rttpto_pkg::rtt_state_t state_r;
  rttpto_pkg::rtt_state_t state_nxt;
  rttpto_pkg::status_t    status_nxt;
  logic                   s2_valid_r;
  rttpto_pkg::rtt_state_t s2_state_r;
  rttpto_pkg::status_t    s2_status_r;

  // stage 3: output register
  logic                          s3_valid_r;
  rttpto_pkg::rtt_state_t        s3_state_r;
  rttpto_pkg::status_t           s3_status_r;
  logic [rttpto_pkg::PTO_W-1:0]  s3_base_r;
  logic [rttpto_pkg::PTO_W-1:0]  s3_with_r;
  logic [rttpto_pkg::PTO_W-1:0]  base_nxt;
  logic [rttpto_pkg::PTO_W-1:0]  with_nxt;

  // advance conditions, back to front
  logic s3_ready;
  logic s2_ready;
  logic s1_ready;
  logic s1_adv;
  logic s2_adv;
  logic in_fire;

  assign s3_ready = !s3_valid_r || out_ch.ready;
  assign s2_adv   = s2_valid_r && s3_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_adv   = s1_valid_r && s2_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_fire  = in_ch.valid && s1_ready;

  assign in_ch.ready = s1_ready;

  rttpto_update u_update (
    .cur    (state_r),
    .sample (s1_sample_r),
    .ack    (s1_ack_r),
    .upd    (state_nxt),
    .status (status_nxt)
  );

  rttpto_pto u_pto (
    .smoothed       (s2_state_r.smoothed),
    .deviation      (s2_state_r.deviation),
    .max_ack_delay  (max_ack_delay_r),
    .pto_base       (base_nxt),
    .pto_with_delay (with_nxt)
  );

  // control and estimator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ack_delay_r <= '0;
      state_r         <= '0;
      s1_valid_r      <= 1'b0;
      s2_valid_r      <= 1'b0;
      s3_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_ack_delay_r <= cfg_wdata;
      end
      // commit the update exactly once, as the sample leaves stage 1
      if (s1_adv) begin
        state_r <= state_nxt;
      end
      if (s1_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_ch.rtt_sample;
      s1_ack_r    <= in_ch.ack_delay;
    end
    if (s1_adv) begin
      s2_state_r  <= state_nxt;
      s2_status_r <= status_nxt;
    end
    if (s2_adv) begin
      s3_state_r  <= s2_state_r;
      s3_status_r <= s2_status_r;
      s3_base_r   <= base_nxt;
      s3_with_r   <= with_nxt;
    end
  end

  assign out_ch.valid          = s3_valid_r;
  assign out_ch.status         = s3_status_r;
  assign out_ch.latest_rtt     = s3_state_r.latest;
  assign out_ch.min_rtt        = s3_state_r.minimum;
  assign out_ch.smoothed_rtt   = s3_state_r.smoothed;
  assign out_ch.rtt_deviation  = s3_state_r.deviation;
  assign out_ch.pto_base       = s3_base_r;
  assign out_ch.pto_with_delay = s3_with_r;

endmodule

`default_nettype wire

// File: rtl/rttpto_update.sv
// ----------------------------------------------------------------------------
// rttpto_update: estimator state update
// Min tracking, ack delay adjustment and the integer EWMA update for one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module rttpto_update (
  input  wire rttpto_pkg::rtt_state_t           cur,
  input  wire logic [rttpto_pkg::TIME_W-1:0]    sample,
  input  wire logic [rttpto_pkg::TIME_W-1:0]    ack,
  output rttpto_pkg::rtt_state_t                upd,
  output rttpto_pkg::status_t                   status
);

  logic [rttpto_pkg::TIME_W-1:0] min_new;
  logic [rttpto_pkg::TIME_W-1:0] adj;
  logic [rttpto_pkg::TIME_W-1:0] diff;
  logic [rttpto_pkg::TIME_W+1:0] dev_sum;
  logic [rttpto_pkg::TIME_W+2:0] smo_sum;

  always_comb begin
    upd    = cur;
    status = rttpto_pkg::STATUS_OK;

    min_new = ((cur.minimum == '0) || (cur.minimum > sample)) ? sample : cur.minimum;
    adj     = ((sample - min_new) >= ack) ? (sample - ack) : sample;
    diff    = (cur.smoothed >= adj) ? (cur.smoothed - adj) : (adj - cur.smoothed);

    // 3*dev + diff and 7*smooth + sample, wide enough to never wrap
    dev_sum = {1'b0, cur.deviation, 1'b0} + {2'b00, cur.deviation} + {2'b00, diff};
    smo_sum = {cur.smoothed, 3'b000} - {3'b000, cur.smoothed} + {3'b000, adj};

    if (sample == '0) begin
      status = rttpto_pkg::STATUS_ZERO;
    end else begin
      upd.minimum = min_new;
      upd.latest  = adj;
      if (cur.smoothed == '0) begin
        upd.smoothed  = adj;
        upd.deviation = {1'b0, adj[rttpto_pkg::TIME_W-1:1]};
      end else begin
        upd.deviation = dev_sum[rttpto_pkg::TIME_W+1:2];
        upd.smoothed  = smo_sum[rttpto_pkg::TIME_W+2:3];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/rttpto_pto.sv
// ----------------------------------------------------------------------------
// rttpto_pto: probe timeout computation
// Smoothed RTT plus max(4*deviation, floor), with and without max ack delay; PTO_NONE while smoothed is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rttpto_pto (
  input  wire logic [rttpto_pkg::TIME_W-1:0]  smoothed,
  input  wire logic [rttpto_pkg::TIME_W-1:0]  deviation,
  input  wire logic [rttpto_pkg::DELAY_W-1:0] max_ack_delay,
  output logic [rttpto_pkg::PTO_W-1:0]        pto_base,
  output logic [rttpto_pkg::PTO_W-1:0]        pto_with_delay
);

  logic [rttpto_pkg::PTO_W-1:0] term;
  logic [rttpto_pkg::PTO_W-1:0] base;

  // sums stay below 2^35 for 32-bit times, so no saturation is needed
  always_comb begin
    term = {1'b0, deviation, 2'b00};
    if (term < rttpto_pkg::PTO_FLOOR) begin
      term = rttpto_pkg::PTO_FLOOR;
    end
    base = {3'b000, smoothed} + term;
    if (smoothed == '0) begin
      pto_base       = rttpto_pkg::PTO_NONE;
      pto_with_delay = rttpto_pkg::PTO_NONE;
    end else begin
      pto_base       = base;
      pto_with_delay = base + {11'd0, max_ack_delay};
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RTT estimator with probe timeout
// Streams RTT samples through the valid/ready input channel, predicts every
// estimator result in-bench and checks the result channel field by field.
// Phases switch max_ack_delay while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb_top;
  import rttpto_pkg::*;

  localparam int          QUIET_LIMIT  = 5000;
  localparam int          PHASE_ITEMS  = 240;
  localparam int          RANDOM_PHASES = 8;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [63:0] PTO_SAT      = 64'h7_FFFF_FFFF;

  typedef struct {
    logic [TIME_W-1:0] rtt;
    logic [TIME_W-1:0] ack;
  } rtt_sample_t;

  typedef struct {
    status_t           status;
    logic [TIME_W-1:0] latest;
    logic [TIME_W-1:0] minimum;
    logic [TIME_W-1:0] smoothed;
    logic [TIME_W-1:0] deviation;
    logic [PTO_W-1:0]  pto_base;
    logic [PTO_W-1:0]  pto_delay;
  } rtt_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [DELAY_W-1:0] cfg_wdata;

  rttpto_in_if  in_bus ();
  rttpto_out_if out_bus ();

  rtt_estimator_pto i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Estimator copy kept by the bench, plus the shadow of max_ack_delay.
  rtt_state_t        est;
  logic [DELAY_W-1:0] delay_shadow;

  rtt_sample_t pending_samples[$];
  rtt_result_t expected_results[$];

  bit gaps_on;
  int mismatches;
  int quiet_cycles;
  int in_gap;
  int out_stall;
  bit in_next_valid;
  rtt_result_t want;

  // Generator-side view of the minimum, used to aim ack delays at the
  // subtraction boundary (sample - min == ack_delay).
  logic [TIME_W-1:0] gen_min;
  logic [TIME_W-1:0] rtt_center;

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the estimator by one sample and return the result it reports.
  function automatic rtt_result_t advance_estimator(input logic [TIME_W-1:0] sample_in,
                                                    input logic [TIME_W-1:0] ack_in);
    logic [TIME_W-1:0] sample;
    logic [TIME_W-1:0] diff;
    logic [63:0]       term;
    logic [63:0]       base;
    logic [63:0]       with_delay;
    rtt_result_t       r;
    sample = sample_in;
    if (sample == '0) begin
      // Rejected sample: state stays, report what is there.
      r.status = STATUS_ZERO;
    end else begin
      r.status = STATUS_OK;
      if (est.minimum == '0 || est.minimum > sample) est.minimum = sample;
      // Strip the ack delay only if it does not push below the minimum.
      if (sample - est.minimum >= ack_in) sample = sample - ack_in;
      est.latest = sample;
      if (est.smoothed == '0) begin
        est.smoothed  = sample;
        est.deviation = sample >> 1;
      end else begin
        // Deviation uses the smoothed value from before this update.
        diff = (est.smoothed >= sample) ? est.smoothed - sample : sample - est.smoothed;
        est.deviation = TIME_W'((64'(est.deviation) * 3 + 64'(diff)) >> 2);
        est.smoothed  = TIME_W'((64'(est.smoothed) * 7 + 64'(sample)) >> 3);
      end
    end
    if (est.smoothed == '0) begin
      r.pto_base  = PTO_NONE;
      r.pto_delay = PTO_NONE;
    end else begin
      term = 64'(est.deviation) << 2;
      if (term < 64'(PTO_FLOOR)) term = 64'(PTO_FLOOR);
      base = 64'(est.smoothed) + term;
      if (base > PTO_SAT) base = PTO_SAT;
      with_delay = base + 64'(delay_shadow);
      if (with_delay > PTO_SAT) with_delay = PTO_SAT;
      r.pto_base  = PTO_W'(base);
      r.pto_delay = PTO_W'(with_delay);
    end
    r.latest    = est.latest;
    r.minimum   = est.minimum;
    r.smoothed  = est.smoothed;
    r.deviation = est.deviation;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [PTO_W-1:0] exp_val,
                             input logic [PTO_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Queue one sample and keep the generator's minimum in step.
  task automatic queue_sample(input logic [TIME_W-1:0] rtt, input logic [TIME_W-1:0] ack);
    rtt_sample_t s;
    if (rtt != '0 && (gen_min == '0 || rtt < gen_min)) gen_min = rtt;
    s.rtt = rtt;
    s.ack = ack;
    pending_samples.push_back(s);
  endtask

  // Hold until every queued sample is sent and every result is back.
  task automatic drain_pipeline();
    while (!(pending_samples.size() == 0 && expected_results.size() == 0 && !in_bus.valid))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_delay(input logic [DELAY_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    delay_shadow = value;
  endtask

  task automatic queue_random_sample();
    logic [TIME_W-1:0] rtt;
    logic [TIME_W-1:0] ack;
    logic [TIME_W-1:0] min_after;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)       rtt = '0;
    else if (r < 60) rtt = rtt_center - (rtt_center >> 3) + $urandom_range(0, rtt_center >> 2);
    else if (r < 75) rtt = $urandom_range(1, 2000);
    else if (r < 90) rtt = $urandom();
    else             rtt = 32'hFFFF_FFFF - $urandom_range(0, 1000);
    min_after = (rtt != '0 && (gen_min == '0 || rtt < gen_min)) ? rtt : gen_min;
    r = $urandom_range(0, 99);
    if (r < 30)      ack = '0;
    else if (r < 55) ack = $urandom_range(0, rtt >> 2);
    else if (r < 70) ack = rtt - min_after + $urandom_range(0, 1);
    else if (r < 85) ack = $urandom();
    else             ack = 32'hFFFF_FFFF;
    queue_sample(rtt, ack);
  endtask

  // Driver: present queued samples, predict each one as it is accepted.
  always @(posedge clk) begin : drive_samples
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap = 0;
    end else begin
      in_next_valid = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        expected_results.push_back(advance_estimator(in_bus.rtt_sample, in_bus.ack_delay));
        in_next_valid = 1'b0;
        in_gap = gaps_on ? idle_gap() : 0;
      end
      if (!in_next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_samples.size() > 0) begin
          in_bus.rtt_sample <= pending_samples[0].rtt;
          in_bus.ack_delay  <= pending_samples[0].ack;
          void'(pending_samples.pop_front());
          in_next_valid = 1'b1;
        end
      end
      // One assignment per edge keeps back-to-back transactions glitch free.
      in_bus.valid <= in_next_valid;
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no prediction pending");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status",         PTO_W'(want.status),   PTO_W'(out_bus.status));
          check_field("latest_rtt",     PTO_W'(want.latest),   PTO_W'(out_bus.latest_rtt));
          check_field("min_rtt",        PTO_W'(want.minimum),  PTO_W'(out_bus.min_rtt));
          check_field("smoothed_rtt",   PTO_W'(want.smoothed), PTO_W'(out_bus.smoothed_rtt));
          check_field("rtt_deviation",  PTO_W'(want.deviation),
                      PTO_W'(out_bus.rtt_deviation));
          check_field("pto_base",       want.pto_base,         out_bus.pto_base);
          check_field("pto_with_delay", want.pto_delay,        out_bus.pto_with_delay);
        end
        out_stall = gaps_on ? idle_gap() : 0;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin : count_quiet
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_bus.valid      = 1'b0;
    in_bus.rtt_sample = '0;
    in_bus.ack_delay  = '0;
    out_bus.ready     = 1'b0;
    est          = '0;
    delay_shadow = '0;
    gen_min      = '0;
    rtt_center   = 32'd1000;
    gaps_on      = 1'b1;
    mismatches   = 0;
    quiet_cycles = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the widest max_ack_delay.
    write_max_delay(24'hFF_FFFF);
    queue_sample(32'd0, 32'd0);                    // zero before any sample
    queue_sample(32'd0, 32'hFFFF_FFFF);
    queue_sample(32'd1000, 32'd0);                 // first sample seeds smoothing
    repeat (4) queue_sample(32'd1000, 32'd0);      // deviation decays to the floor
    queue_sample(32'd5000, 32'd4000);              // ack exactly at the boundary
    queue_sample(32'd5000, 32'd4001);              // one past: no subtraction
    queue_sample(32'd1, 32'd0);                    // new minimum
    queue_sample(32'd1, 32'd1);
    queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (3) queue_sample(32'hFFFF_FFFF, 32'd0); // push PTO toward its top
    queue_sample(32'd0, 32'd12345);                // zero after samples
    queue_sample(32'd2, 32'hFFFF_FFFF);
    queue_sample(32'hAAAA_AAAA, 32'h5555_5555);
    queue_sample(32'h5555_5555, 32'hAAAA_AAAA);
    drain_pipeline();

    // Random phases, each with its own max_ack_delay and RTT center.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: write_max_delay('0);
        1: write_max_delay(24'hFF_FFFF);
        2: write_max_delay(DELAY_W'(200));
        3: write_max_delay(24'h80_0000);
        default: write_max_delay(DELAY_W'($urandom_range(0, 24'hFF_FFFF)));
      endcase
      gaps_on    = (p % 3) != 2;                   // some phases run at full rate
      rtt_center = $urandom_range(1000, 500000);
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random_sample();
      drain_pipeline();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
